// ===== src/crclfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crclfc_pkg
// Shared types, constants and the byte-wise CRC-32 update for the
// length-prefixed frame checker.
// ----------------------------------------------------------------------------
package crclfc_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OutDataW = 72;  // 66 payload bits padded to bytes

  localparam logic [WordW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [WordW-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] CntMax  = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] MinLen  = 32'd12;  // header and trailer bytes
  localparam logic [WordW-1:0] LenEnd  = 32'd4;   // first byte after length word
  localparam logic [WordW-1:0] MetaEnd = 32'd8;   // first byte after meta word

  typedef enum logic [StatusW-1:0] {
    STS_OK       = 2'd0,
    STS_SHORT    = 2'd1,
    STS_LEN_MISM = 2'd2,
    STS_CRC_MISM = 2'd3
  } status_t;

  typedef struct packed {
    logic [WordW-1:0] payload_bytes;
    logic [WordW-1:0] meta_word;
    status_t          status;
  } result_t;

  // Reflected CRC-32, one byte, LSB first.
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc_in,
                                                input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc_in ^ {{(WordW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/crc32_length_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_length_frame_checker
// Checks length-prefixed frames carrying a trailing big-endian CRC-32.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one frame byte per request, in_tlast on the final byte.
//   out_* : one status request per frame, issued after its last byte.
//   Frame layout: BE length word, BE meta word, payload, BE CRC-32 over all
//   bytes but the last four. Status: too short (<= 12 bytes), length mismatch,
//   CRC mismatch, checked in that order, else ok.
// Throughput: one byte per cycle unless a last byte waits on the output; the
//   byte-wise CRC update sits between the input register and the frame state registers.
// Result: the last byte passes the input register, then the result register, to out_tvalid.
// Reset: clears valid flags and frame state (CRC register to all ones).
//   Frame state also returns to reset after every frame.
// Stall: mid-frame bytes never wait on the output. A last byte waits in the
//   input register only while the previous status is still unread; then
//   in_tready drops until out_tready takes it.
// ----------------------------------------------------------------------------
module crc32_length_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [crclfc_pkg::OutDataW-1:0] out_tdata  // [1:0] status, [33:2] meta_word,
                                                     // [65:34] payload_bytes, [71:66] zero
);

  localparam int unsigned WordW = crclfc_pkg::WordW;
  localparam int unsigned ByteW = crclfc_pkg::ByteW;

  // input register
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_last_r;
  logic [ByteW-1:0] s1_data_r;
  logic             s1_adv;
  logic             in_fire;

  // frame state
  logic [WordW-1:0] byte_count_r, byte_count_nxt;
  logic [WordW-1:0] length_r, length_nxt;
  logic [WordW-1:0] meta_r, meta_nxt;
  logic [WordW-1:0] crc_r, crc_nxt;
  logic [WordW-1:0] tail_r, tail_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  crclfc_pkg::result_t   res_r, res_nxt;

  logic [WordW-1:0] cnt_upd, len_upd, meta_upd, crc_upd, tail_upd;

  assign in_fire   = in_tvalid && in_tready;
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // per-byte state update
  always_comb begin
    len_upd  = length_r;
    meta_upd = meta_r;
    crc_upd  = crc_r;
    if (byte_count_r < crclfc_pkg::LenEnd) begin
      len_upd = {length_r[WordW-ByteW-1:0], s1_data_r};
    end else if (byte_count_r < crclfc_pkg::MetaEnd) begin
      meta_upd = {meta_r[WordW-ByteW-1:0], s1_data_r};
    end
    // a byte enters the CRC only once it leaves the four-byte trailer window
    if (byte_count_r >= crclfc_pkg::LenEnd) begin
      crc_upd = crclfc_pkg::crc_byte(crc_r, tail_r[WordW-1 -: ByteW]);
    end
    tail_upd = {tail_r[WordW-ByteW-1:0], s1_data_r};
    cnt_upd  = (byte_count_r == crclfc_pkg::CntMax) ? byte_count_r
                                                     : byte_count_r + 32'd1;
  end

  // frame-end verdict
  always_comb begin
    res_nxt = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
      if (cnt_upd <= crclfc_pkg::MinLen) begin
        res_nxt.status        = crclfc_pkg::STS_SHORT;
        res_nxt.meta_word     = '0;
        res_nxt.payload_bytes = '0;
      end else begin
        res_nxt.meta_word     = meta_upd;
        res_nxt.payload_bytes = cnt_upd - crclfc_pkg::MinLen;
        priority if (cnt_upd != len_upd) begin
          res_nxt.status = crclfc_pkg::STS_LEN_MISM;
        end else if ((crc_upd ^ crclfc_pkg::CrcInit) != tail_upd) begin
          res_nxt.status = crclfc_pkg::STS_CRC_MISM;
        end else begin
          res_nxt.status = crclfc_pkg::STS_OK;
        end
      end
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    length_nxt     = length_r;
    meta_nxt       = meta_r;
    crc_nxt        = crc_r;
    tail_nxt       = tail_r;
    if (s1_adv) begin
      if (s1_last_r) begin
        byte_count_nxt = '0;
        length_nxt     = '0;
        meta_nxt       = '0;
        crc_nxt        = crclfc_pkg::CrcInit;
        tail_nxt       = '0;
      end else begin
        byte_count_nxt = cnt_upd;
        length_nxt     = len_upd;
        meta_nxt       = meta_upd;
        crc_nxt        = crc_upd;
        tail_nxt       = tail_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      length_r     <= '0;
      meta_r       <= '0;
      crc_r        <= crclfc_pkg::CrcInit;
      tail_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      length_r     <= length_nxt;
      meta_r       <= meta_nxt;
      crc_r        <= crc_nxt;
      tail_r       <= tail_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (byte_count_r == '0 && crc_r == crclfc_pkg::CrcInit))
    else $error("frame state not cleared after last byte");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_tready))
    else $error("input stalled without a pending status");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status == crclfc_pkg::STS_SHORT)
      |-> (res_r.meta_word == '0 && res_r.payload_bytes == '0))
    else $error("short frame reports nonzero fields");

  a_long_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.status != crclfc_pkg::STS_SHORT)
      |-> (res_r.payload_bytes != '0))
    else $error("checked frame reports empty payload");

endmodule

// ===== bench/tb_crc32_length_frame_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc32_length_frame_checker
// Self-checking bench for the length-prefixed CRC-32 frame checker. Frames
// are built here with a correct or a damaged length word and CRC trailer, or
// as raw noise, and are streamed one byte per request. A bit-level model
// tracks the frame state and queues one expected status per frame. A monitor
// compares every result request field by field. Both sides throttle at random.
// ----------------------------------------------------------------------------
module tb_crc32_length_frame_checker;

  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned RandomBytes  = 1300;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned IdlePct      = 7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  // no random idling on either side while set
  logic        steady     = 1'b0;

  // frame state mirror
  logic [31:0] frame_bytes = '0;
  logic [31:0] len_shift   = '0;
  logic [31:0] meta_shift  = '0;
  logic [31:0] crc_run     = crclfc_pkg::CrcInit;
  logic [31:0] tail_bytes  = '0;

  crclfc_pkg::result_t pending_status[$];
  int unsigned status_seen[4];
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned fault_count  = 0;
  int unsigned idle_cycles  = 0;

  crc32_length_frame_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // reflected CRC-32, one byte, LSB first
  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ crclfc_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void predict_frame_byte(input logic [7:0] b, input logic last);
    crclfc_pkg::result_t r;
    if (frame_bytes < crclfc_pkg::LenEnd) begin
      len_shift = {len_shift[23:0], b};
    end else if (frame_bytes < crclfc_pkg::MetaEnd) begin
      meta_shift = {meta_shift[23:0], b};
    end
    // a byte reaches the CRC only once it leaves the four-byte trailer window
    if (frame_bytes >= crclfc_pkg::LenEnd) begin
      crc_run = crc32_step(crc_run, tail_bytes[31:24]);
    end
    tail_bytes = {tail_bytes[23:0], b};
    if (frame_bytes != crclfc_pkg::CntMax) begin
      frame_bytes = frame_bytes + 1;
    end
    if (!last) return;
    r = '0;
    if (frame_bytes <= crclfc_pkg::MinLen) begin
      r.status = crclfc_pkg::STS_SHORT;
    end else begin
      r.meta_word     = meta_shift;
      r.payload_bytes = frame_bytes - crclfc_pkg::MinLen;
      if (frame_bytes != len_shift) begin
        r.status = crclfc_pkg::STS_LEN_MISM;
      end else if ((crc_run ^ crclfc_pkg::CrcInit) != tail_bytes) begin
        r.status = crclfc_pkg::STS_CRC_MISM;
      end else begin
        r.status = crclfc_pkg::STS_OK;
      end
    end
    pending_status = {pending_status, r};
    status_seen[r.status]++;
    frames_sent++;
    frame_bytes = '0;
    len_shift   = '0;
    meta_shift  = '0;
    crc_run     = crclfc_pkg::CrcInit;
    tail_bytes  = '0;
  endfunction

  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // result monitor
  always @(posedge clk) begin
    crclfc_pkg::result_t got;
    crclfc_pkg::result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got = crclfc_pkg::result_t'(out_tdata[65:0]);
      if (pending_status.size() == 0) begin
        report_fault($sformatf("unexpected result %h", out_tdata));
      end else begin
        want = pending_status.pop_front();
        if (got.status !== want.status || got.meta_word !== want.meta_word ||
            got.payload_bytes !== want.payload_bytes || out_tdata[71:66] !== 6'h0) begin
          report_fault($sformatf(
            "status exp %0d got %0d, meta exp %h got %h, payload exp %0d got %0d, pad %b",
            want.status, got.status, want.meta_word, got.meta_word,
            want.payload_bytes, got.payload_bytes, out_tdata[71:66]));
        end
      end
    end
  end

  // receiver throttle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99, 0) >= IdlePct);
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == StallLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99, 0) < IdlePct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predict_frame_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] body[$]);
    foreach (body[i]) send_byte(body[i], i == body.size() - 1);
  endtask

  // raw bytes, no header structure; fill < 0 gives random content
  task automatic send_raw(input int n, input int fill);
    logic [7:0] body[$];
    for (int i = 0; i < n; i++) begin
      body = {body, (fill < 0 ? 8'($urandom_range(255, 0)) : 8'(fill))};
    end
    send_bytes(body);
  endtask

  // well-formed frame; the xor masks damage the length word or the CRC trailer
  task automatic send_frame(input int plen, input logic [31:0] meta,
                            input logic [31:0] len_xor, input logic [31:0] crc_xor,
                            input int fill);
    logic [7:0]  body[$];
    logic [31:0] len_field;
    logic [31:0] crc;
    len_field = (plen + 12) ^ len_xor;
    for (int i = 3; i >= 0; i--) body = {body, len_field[i*8 +: 8]};
    for (int i = 3; i >= 0; i--) body = {body, meta[i*8 +: 8]};
    for (int i = 0; i < plen; i++) begin
      body = {body, (fill < 0 ? 8'($urandom_range(255, 0)) : 8'(fill))};
    end
    crc = crclfc_pkg::CrcInit;
    foreach (body[i]) crc = crc32_step(crc, body[i]);
    crc = crc ^ crclfc_pkg::CrcInit ^ crc_xor;
    for (int i = 3; i >= 0; i--) body = {body, crc[i*8 +: 8]};
    send_bytes(body);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic test_short_frames();
    send_raw(1, 8'hFF);
    // twelve bytes is still too short even with a valid header
    send_frame(0, 32'hA5A5_5A5A, 32'h0, 32'h0, -1);
  endtask

  task automatic test_good_frames();
    send_frame(1, 32'hFFFF_FFFF, 32'h0, 32'h0, 8'hFF);
    send_frame(1, 32'h0000_0000, 32'h0, 32'h0, 8'h00);
  endtask

  task automatic test_bad_length();
    send_frame(2, $urandom, 32'h8000_0000, 32'h0, -1);
    // length word of all ones
    send_frame(1, $urandom, 32'd13 ^ 32'hFFFF_FFFF, 32'h0, -1);
  endtask

  task automatic test_bad_crc();
    send_frame(1, $urandom, 32'h0, 32'h0000_0001, -1);
    // both damaged: the length check wins
    send_frame(1, $urandom, 32'h0000_0001, 32'h8000_0000, -1);
  endtask

  task automatic test_drain_between_frames();
    for (int i = 0; i < 4; i++) begin
      send_frame($urandom_range(8, 0), $urandom, 32'h0, 32'h0, -1);
      wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    steady <= 1'b1;
    for (int i = 0; i < 6; i++) send_raw(1, -1);
    for (int i = 0; i < 16; i++) send_frame($urandom_range(8, 0), $urandom, 32'h0, 32'h0, -1);
    steady <= 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned start_bytes;
    int          pick;
    int          plen;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < RandomBytes) begin
      pick = $urandom_range(99, 0);
      plen = ($urandom_range(9, 0) == 0) ? $urandom_range(150, 25) : $urandom_range(24, 0);
      if (pick < 60) begin
        send_frame(plen, $urandom, 32'h0, 32'h0, -1);
      end else if (pick < 70) begin
        send_frame(plen, $urandom, 32'd1 << $urandom_range(31, 0), 32'h0, -1);
      end else if (pick < 80) begin
        send_frame(plen, $urandom, 32'h0, 32'd1 << $urandom_range(31, 0), -1);
      end else begin
        send_raw($urandom_range(30, 1), -1);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_frames();
    test_good_frames();
    test_bad_length();
    test_bad_crc();
    test_drain_between_frames();
    test_back_to_back();
    test_random_traffic();
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    $display("covered %0d frames, %0d bytes: ok %0d, short %0d, bad length %0d, bad crc %0d",
             frames_sent, bytes_sent,
             status_seen[crclfc_pkg::STS_OK], status_seen[crclfc_pkg::STS_SHORT],
             status_seen[crclfc_pkg::STS_LEN_MISM], status_seen[crclfc_pkg::STS_CRC_MISM]);
    $display("payloads up to 150 bytes with both sides throttled; %0d mismatches",
             fault_count);
    if (fault_count == 0 && pending_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
